// ----- rtl/kbr_pkg.sv -----
// kbr_pkg: shared types and codes for the keyboard rollover report builder
// no dependencies; imported by kbr_batch_ctrl, the top level and the testbench
`timescale 1ns / 1ps

package kbr_pkg;

  // number of slot ports on the report, fixed by the report format
  localparam int unsigned OUT_SLOTS = 6;

  // request kinds
  localparam logic REQ_KEY         = 1'b0;
  localparam logic REQ_RELEASE_ALL = 1'b1;

  // per-request result status
  typedef enum logic [1:0] {
    ST_COMMIT = 2'd0,
    ST_OPEN   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // one result as it leaves the batch controller
  typedef struct packed {
    status_e                     status;
    logic                        report_valid;
    logic [7:0]                  modifiers;
    logic [OUT_SLOTS-1:0][7:0]   slots;
  } result_t;

endpackage

// ----- rtl/kbr_key_apply.sv -----
// kbr_key_apply: applies one key event to a working report copy
// combinational; no dependencies
`timescale 1ns / 1ps

module kbr_key_apply #(
  parameter int unsigned KEY_SLOTS         = 6,
  parameter int unsigned MODIFIER_FLAG_BIT = 8
) (
  input  logic [15:0]                code_i,
  input  logic                       press_i,
  input  logic [7:0]                 mods_i,
  input  logic [KEY_SLOTS-1:0][7:0]  keys_i,
  output logic [7:0]                 mods_o,
  output logic [KEY_SLOTS-1:0][7:0]  keys_o,
  output logic                       ok_o
);

  logic                      is_mod;
  logic                      mod_ok;
  logic                      plain_ok;
  logic [KEY_SLOTS-1:0]      match;
  logic [KEY_SLOTS-1:0]      empty;
  logic [KEY_SLOTS-1:0]      first_empty;
  logic [KEY_SLOTS-1:0]      shift_here;
  logic [KEY_SLOTS-1:0][7:0] keys_removed;
  logic [KEY_SLOTS-1:0][7:0] keys_added;
  logic                      hit;
  logic                      has_empty;

  // code classification
  assign is_mod   = code_i[MODIFIER_FLAG_BIT];
  assign mod_ok   = $onehot(code_i[7:0]);
  assign plain_ok = (code_i[15:8] == 8'd0) && (code_i[7:0] != 8'd0);

  // per-slot compare, first empty slot and pack-forward on release
  for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_slot
    localparam logic [KEY_SLOTS-1:0] LowMask = KEY_SLOTS'((1 << k) - 1);
    localparam logic [KEY_SLOTS-1:0] IncMask = KEY_SLOTS'((1 << (k + 1)) - 1);

    assign match[k]       = (keys_i[k] == code_i[7:0]);
    assign empty[k]       = (keys_i[k] == 8'd0);
    assign first_empty[k] = empty[k] & ~|(empty & LowMask);
    assign shift_here[k]  = |(match & IncMask);
    assign keys_added[k]  = first_empty[k] ? code_i[7:0] : keys_i[k];

    if (k + 1 < KEY_SLOTS) begin : g_mid
      assign keys_removed[k] = shift_here[k] ? keys_i[k+1] : keys_i[k];
    end else begin : g_end
      assign keys_removed[k] = shift_here[k] ? 8'd0 : keys_i[k];
    end
  end

  assign hit       = |match;
  assign has_empty = |empty;

  // select the edit that this event makes
  always_comb begin
    mods_o = mods_i;
    keys_o = keys_i;
    ok_o   = 1'b0;
    if (is_mod) begin
      ok_o = mod_ok;
      if (mod_ok) begin
        mods_o = press_i ? (mods_i | code_i[7:0]) : (mods_i & ~code_i[7:0]);
      end
    end else if (plain_ok) begin
      if (hit) begin
        ok_o = 1'b1;
        if (!press_i) begin
          keys_o = keys_removed;
        end
      end else if (!press_i) begin
        ok_o = 1'b1;
      end else if (has_empty) begin
        ok_o   = 1'b1;
        keys_o = keys_added;
      end
    end
  end

endmodule

// ----- rtl/kbr_batch_ctrl.sv -----
// kbr_batch_ctrl: committed and working reports, batch bookkeeping
// depends on kbr_pkg and kbr_key_apply
`timescale 1ns / 1ps

module kbr_batch_ctrl #(
  parameter int unsigned KEY_SLOTS         = 6,
  parameter int unsigned MODIFIER_FLAG_BIT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              req_type_i,
  input  logic [15:0]       key_code_i,
  input  logic              key_pressed_i,
  input  logic              batch_last_i,
  output kbr_pkg::result_t  result_o
);

  import kbr_pkg::*;

  logic [7:0]                held_mods_q, held_mods_d;
  logic [KEY_SLOTS-1:0][7:0] held_keys_q, held_keys_d;
  logic [7:0]                work_mods_q, work_mods_d;
  logic [KEY_SLOTS-1:0][7:0] work_keys_q, work_keys_d;
  logic                      open_q, open_d;
  logic                      failed_q, failed_d;

  logic [7:0]                base_mods;
  logic [KEY_SLOTS-1:0][7:0] base_keys;
  logic                      base_failed;
  logic [7:0]                new_mods;
  logic [KEY_SLOTS-1:0][7:0] new_keys;
  logic                      apply_ok;
  logic                      failed_now;
  status_e                   status;
  logic                      report_valid;

  // a new batch starts from the committed report
  assign base_mods   = open_q ? work_mods_q : held_mods_q;
  assign base_keys   = open_q ? work_keys_q : held_keys_q;
  assign base_failed = open_q & failed_q;

  kbr_key_apply #(
    .KEY_SLOTS         (KEY_SLOTS),
    .MODIFIER_FLAG_BIT (MODIFIER_FLAG_BIT)
  ) u_apply (
    .code_i  (key_code_i),
    .press_i (key_pressed_i),
    .mods_i  (base_mods),
    .keys_i  (base_keys),
    .mods_o  (new_mods),
    .keys_o  (new_keys),
    .ok_o    (apply_ok)
  );

  assign failed_now = base_failed | ~apply_ok;

  // next state and status for the current request
  always_comb begin
    held_mods_d  = held_mods_q;
    held_keys_d  = held_keys_q;
    work_mods_d  = base_mods;
    work_keys_d  = base_keys;
    open_d       = 1'b0;
    failed_d     = 1'b0;
    status       = ST_COMMIT;
    report_valid = 1'b0;
    if (req_type_i == REQ_RELEASE_ALL) begin
      held_mods_d  = '0;
      held_keys_d  = '0;
      work_mods_d  = '0;
      work_keys_d  = '0;
      report_valid = 1'b1;
    end else begin
      if (!failed_now) begin
        work_mods_d = new_mods;
        work_keys_d = new_keys;
      end
      if (batch_last_i) begin
        if (failed_now) begin
          status = ST_REJECT;
        end else begin
          held_mods_d  = new_mods;
          held_keys_d  = new_keys;
          report_valid = 1'b1;
        end
      end else begin
        status   = ST_OPEN;
        open_d   = 1'b1;
        failed_d = failed_now;
      end
    end
  end

  // state registers, updated once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mods_q <= '0;
      held_keys_q <= '0;
      work_mods_q <= '0;
      work_keys_q <= '0;
      open_q      <= 1'b0;
      failed_q    <= 1'b0;
    end else if (step_i) begin
      held_mods_q <= held_mods_d;
      held_keys_q <= held_keys_d;
      work_mods_q <= work_mods_d;
      work_keys_q <= work_keys_d;
      open_q      <= open_d;
      failed_q    <= failed_d;
    end
  end

  // result carries the committed report after this request
  assign result_o.status       = status;
  assign result_o.report_valid = report_valid;
  assign result_o.modifiers    = held_mods_d;

  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_out
    if (j < KEY_SLOTS) begin : g_used
      assign result_o.slots[j] = held_keys_d[j];
    end else begin : g_unused
      assign result_o.slots[j] = 8'd0;
    end
  end

endmodule

// ----- rtl/keyboard_rollover_report_builder_unit.sv -----
// keyboard_rollover_report_builder_unit: top level with result register
// depends on kbr_pkg and kbr_batch_ctrl
`timescale 1ns / 1ps

// Builds a boot-keyboard style report (modifier byte plus KEY_SLOTS key
// slots) from a stream of key requests. Each accepted request gives exactly
// one result: status (committed, batch open, batch rejected), a flag that a
// new report was committed, and the committed report after that request.
// One request is accepted every cycle while the output register is free or
// draining, and its result appears there in the cycle after acceptance. The
// rate is set by the once-per-request update of the report state registers,
// with all slot compares in parallel. A new request is taken whenever the
// output register is empty or its result is being taken in the same cycle.

module keyboard_rollover_report_builder_unit #(
  parameter int unsigned KEY_SLOTS         = 6,
  parameter int unsigned MODIFIER_FLAG_BIT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [15:0] key_code_i,
  input  logic        key_pressed_i,
  input  logic        batch_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        report_valid_o,
  output logic [7:0]  modifier_bits_o,
  output logic [7:0]  slot_0_o,
  output logic [7:0]  slot_1_o,
  output logic [7:0]  slot_2_o,
  output logic [7:0]  slot_3_o,
  output logic [7:0]  slot_4_o,
  output logic [7:0]  slot_5_o
);

  import kbr_pkg::*;

  logic    step;
  result_t result;
  result_t result_q;
  logic    out_valid_q;

  // accept while the result register is free or draining
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign step       = in_valid_i & in_ready_o;

  kbr_batch_ctrl #(
    .KEY_SLOTS         (KEY_SLOTS),
    .MODIFIER_FLAG_BIT (MODIFIER_FLAG_BIT)
  ) u_batch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .req_type_i    (req_type_i),
    .key_code_i    (key_code_i),
    .key_pressed_i (key_pressed_i),
    .batch_last_i  (batch_last_i),
    .result_o      (result)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = result_q.status;
  assign report_valid_o  = result_q.report_valid;
  assign modifier_bits_o = result_q.modifiers;
  assign slot_0_o        = result_q.slots[0];
  assign slot_1_o        = result_q.slots[1];
  assign slot_2_o        = result_q.slots[2];
  assign slot_3_o        = result_q.slots[3];
  assign slot_4_o        = result_q.slots[4];
  assign slot_5_o        = result_q.slots[5];

  // a committed report is only flagged with commit status
  a_valid_means_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && report_valid_o) |-> (status_o == ST_COMMIT))
    else $error("report flagged without commit status");

  // release-all empties the report seen in the next result
  a_release_all_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && req_type_i == REQ_RELEASE_ALL) |=>
      (out_valid_o && report_valid_o && modifier_bits_o == 8'd0 &&
       slot_0_o == 8'd0 && slot_5_o == 8'd0))
    else $error("release-all left keys in the report");

  // input stalls only behind a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("request stalled with free result register");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for keyboard_rollover_report_builder_unit
// depends on kbr_pkg and the rtl of the block; drives requests, predicts reports, checks results
`timescale 1ns / 1ps

module tb;
  import kbr_pkg::*;

  localparam int unsigned KEY_SLOTS    = 6;
  localparam int unsigned MOD_FLAG_BIT = 8;
  localparam int unsigned PHASE_ITEMS  = 270;
  localparam int unsigned HOLD_AFTER   = 100;
  localparam int unsigned LONG_HOLD    = 40;
  localparam int unsigned MAX_REPORTED = 10;

  typedef struct {
    logic        req_type;
    logic [15:0] key_code;
    logic        key_pressed;
    logic        batch_last;
  } key_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = REQ_KEY;
  logic [15:0] key_code_i = '0;
  logic        key_pressed_i = 1'b0;
  logic        batch_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        report_valid_o;
  logic [7:0]  modifier_bits_o;
  logic [7:0]  slot_0_o, slot_1_o, slot_2_o, slot_3_o, slot_4_o, slot_5_o;

  // request stream, expected reports and run bookkeeping
  key_req_t    pending_requests[$];
  result_t     expected_reports[$];
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // predictor copy of the report state
  logic [7:0]  held_mods;
  logic [7:0]  held_keys [KEY_SLOTS];
  logic [7:0]  work_mods;
  logic [7:0]  work_keys [KEY_SLOTS];
  bit          batch_open;
  bit          batch_failed;

  keyboard_rollover_report_builder_unit #(
    .KEY_SLOTS        (KEY_SLOTS),
    .MODIFIER_FLAG_BIT(MOD_FLAG_BIT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .key_code_i     (key_code_i),
    .key_pressed_i  (key_pressed_i),
    .batch_last_i   (batch_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .report_valid_o (report_valid_o),
    .modifier_bits_o(modifier_bits_o),
    .slot_0_o       (slot_0_o),
    .slot_1_o       (slot_1_o),
    .slot_2_o       (slot_2_o),
    .slot_3_o       (slot_3_o),
    .slot_4_o       (slot_4_o),
    .slot_5_o       (slot_5_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // clear the whole report, committed and working
  function automatic void clear_reports();
    held_mods = '0;
    work_mods = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held_keys[i] = '0;
      work_keys[i] = '0;
    end
    batch_open = 1'b0;
    batch_failed = 1'b0;
  endfunction

  // apply one accepted request to the report and queue the report it gives
  function automatic void predict_report(key_req_t r);
    result_t     res;
    logic [7:0]  m;
    bit          ok;
    int          hit;
    int          free;
    res = '0;
    res.status = ST_OPEN;
    res.report_valid = 1'b0;
    if (r.req_type == REQ_RELEASE_ALL) begin
      clear_reports();
      res.status = ST_COMMIT;
      res.report_valid = 1'b1;
    end else begin
      // first key after a commit, reject or release-all opens a batch from the committed report
      if (!batch_open) begin
        work_mods = held_mods;
        for (int i = 0; i < KEY_SLOTS; i++) work_keys[i] = held_keys[i];
        batch_open = 1'b1;
        batch_failed = 1'b0;
      end
      // once a key failed, the rest of the batch is skipped
      if (!batch_failed) begin
        ok = 1'b1;
        if (r.key_code[MOD_FLAG_BIT]) begin
          m = r.key_code[7:0];
          if (m == 8'h00 || (m & (m - 8'd1)) != 8'h00) ok = 1'b0;
          else if (r.key_pressed) work_mods = work_mods | m;
          else work_mods = work_mods & ~m;
        end else if (r.key_code == 16'h0000 || r.key_code > 16'h00ff) begin
          ok = 1'b0;
        end else begin
          hit = -1;
          free = -1;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (hit < 0 && work_keys[i] == r.key_code[7:0]) hit = i;
            if (free < 0 && work_keys[i] == 8'h00) free = i;
          end
          if (hit >= 0) begin
            // release packs the later slots toward the front
            if (!r.key_pressed) begin
              for (int i = hit; i < KEY_SLOTS - 1; i++) work_keys[i] = work_keys[i + 1];
              work_keys[KEY_SLOTS - 1] = 8'h00;
            end
          end else if (r.key_pressed) begin
            if (free < 0) ok = 1'b0;
            else work_keys[free] = r.key_code[7:0];
          end
        end
        if (!ok) batch_failed = 1'b1;
      end
      // commit point
      if (r.batch_last) begin
        if (batch_failed) begin
          res.status = ST_REJECT;
        end else begin
          held_mods = work_mods;
          for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = work_keys[i];
          res.status = ST_COMMIT;
          res.report_valid = 1'b1;
        end
        batch_open = 1'b0;
        batch_failed = 1'b0;
      end
    end
    res.modifiers = held_mods;
    for (int j = 0; j < OUT_SLOTS; j++) begin
      res.slots[j] = (j < KEY_SLOTS) ? held_keys[j] : 8'h00;
    end
    expected_reports.push_back(res);
  endfunction

  function automatic void push_request(logic rt, logic [15:0] code, logic press, logic last);
    key_req_t r;
    r.req_type = rt;
    r.key_code = code;
    r.key_pressed = press;
    r.batch_last = last;
    pending_requests.push_back(r);
  endfunction

  // mostly keys from a small pool so that repeats, releases and full slots happen
  function automatic logic [15:0] random_key_code();
    int unsigned pick;
    logic [15:0] c;
    pick = $urandom_range(99);
    if (pick < 70) begin
      c = 16'(3 + $urandom_range(9));
    end else if (pick < 78) begin
      c = 16'($urandom_range(255, 1));
    end else if (pick < 90) begin
      c = 16'($urandom);
      c[MOD_FLAG_BIT] = 1'b1;
      c[7:0] = 8'h01 << $urandom_range(7);
    end else if (pick < 93) begin
      c = 16'h0000;
    end else if (pick < 96) begin
      // plain code above a byte
      c = 16'($urandom);
      c[MOD_FLAG_BIT] = 1'b0;
      if (c[15:9] == 7'd0) c[15] = 1'b1;
    end else begin
      // modifier code with an arbitrary low byte
      c = 16'($urandom);
      c[MOD_FLAG_BIT] = 1'b1;
    end
    return c;
  endfunction

  // one batch, or a piece of noise; returns the number of requests queued
  function automatic int add_random_batch();
    int unsigned kind;
    int unsigned len;
    int          n;
    kind = $urandom_range(99);
    n = 0;
    if (kind < 5) begin
      push_request(REQ_RELEASE_ALL, 16'($urandom), 1'($urandom), 1'($urandom));
      return 1;
    end
    if (kind < 10) begin
      push_request(REQ_KEY, 16'($urandom), 1'($urandom), 1'($urandom));
      return 1;
    end
    len = $urandom_range(4, 1);
    for (int k = 0; k < len; k++) begin
      push_request(REQ_KEY, random_key_code(), $urandom_range(99) < 65, k == len - 1);
      n++;
      // broken batch: release-all in the middle
      if (k != len - 1 && $urandom_range(99) < 3) begin
        push_request(REQ_RELEASE_ALL, 16'($urandom), 1'($urandom), 1'($urandom));
        n++;
      end
    end
    return n;
  endfunction

  // sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // request driver with prediction at acceptance
  always @(posedge clk_i) begin : drive_requests
    key_req_t cur;
    key_req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cur.req_type = req_type_i;
        cur.key_code = key_code_i;
        cur.key_pressed = key_pressed_i;
        cur.batch_last = batch_last_i;
        predict_report(cur);
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= nxt.req_type;
          key_code_i <= nxt.key_code;
          key_pressed_i <= nxt.key_pressed;
          batch_last_i <= nxt.batch_last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
      out_ready_i <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : check_results
    result_t exp_rep;
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_e'(status_o);
      got.report_valid = report_valid_o;
      got.modifiers = modifier_bits_o;
      got.slots = {slot_5_o, slot_4_o, slot_3_o, slot_2_o, slot_1_o, slot_0_o};
      if (expected_reports.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MAX_REPORTED)
          $display("unexpected result: status %0d valid %0b mods %h slots %h",
                   got.status, got.report_valid, got.modifiers, got.slots);
      end else begin
        exp_rep = expected_reports.pop_front();
        if (got.status != exp_rep.status || got.report_valid != exp_rep.report_valid ||
            got.modifiers != exp_rep.modifiers || got.slots != exp_rep.slots) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTED)
            $display({"report mismatch: exp status %0d valid %0b mods %h slots %h, ",
                      "got status %0d valid %0b mods %h slots %h"},
                     exp_rep.status, exp_rep.report_valid, exp_rep.modifiers, exp_rep.slots,
                     got.status, got.report_valid, got.modifiers, got.slots);
        end
      end
    end
  end

  // stimulus: directed requests, then random batches under four idling mixes
  initial begin : stimulus
    int unsigned added;
    clear_reports();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    push_request(REQ_RELEASE_ALL, 16'hffff, 1'b1, 1'b1);
    push_request(REQ_KEY, 16'h0004, 1'b1, 1'b1);      // batch of one
    push_request(REQ_KEY, 16'h0101, 1'b1, 1'b1);      // modifier bit 0
    push_request(REQ_KEY, 16'hff80, 1'b1, 1'b1);      // modifier bit 7, upper bits set
    push_request(REQ_KEY, 16'h0005, 1'b1, 1'b0);
    push_request(REQ_KEY, 16'h0006, 1'b1, 1'b0);
    push_request(REQ_KEY, 16'h0007, 1'b1, 1'b0);
    push_request(REQ_KEY, 16'h0008, 1'b1, 1'b0);
    push_request(REQ_KEY, 16'h0009, 1'b1, 1'b1);      // all slots used
    push_request(REQ_KEY, 16'h0004, 1'b1, 1'b1);      // press of a held key
    push_request(REQ_KEY, 16'h00ff, 1'b1, 1'b1);      // no free slot
    push_request(REQ_KEY, 16'h0000, 1'b1, 1'b0);      // bad code starts a failed batch
    push_request(REQ_KEY, 16'h0020, 1'b1, 1'b0);
    push_request(REQ_KEY, 16'h0006, 1'b0, 1'b1);
    push_request(REQ_KEY, 16'h0006, 1'b0, 1'b1);      // release packs slots
    push_request(REQ_KEY, 16'h0033, 1'b0, 1'b1);      // release of a key not held
    push_request(REQ_KEY, 16'h0103, 1'b1, 1'b1);      // two modifier bits
    push_request(REQ_KEY, 16'h0100, 1'b1, 1'b1);      // no modifier bit
    push_request(REQ_KEY, 16'h0204, 1'b1, 1'b1);      // plain code above a byte
    push_request(REQ_KEY, 16'h0101, 1'b0, 1'b1);      // modifier release
    push_request(REQ_KEY, 16'h0011, 1'b1, 1'b0);
    push_request(REQ_RELEASE_ALL, 16'h0000, 1'b0, 1'b0);  // abandons the open batch
    push_request(REQ_KEY, 16'h0012, 1'b1, 1'b1);
    push_request(REQ_KEY, 16'h0012, 1'b0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
      added = 0;
      while (added < PHASE_ITEMS) added += add_random_batch();
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
